>>> hdl/esd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helpers for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    // One queued result; term_after appends the string terminator beat.
    typedef struct packed {
        logic       term_after;
        logic       last;
        logic [7:0] data;
    } esd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } esd_qstat_t;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            begin
                d = c - CH_UPPER_A + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            begin
                d = c - CH_LOWER_A + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end
            else
            begin
                hex_digit = {1'b0, d[3:0]};
            end
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/esd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_front
// Takes one character a beat, tracks the escape state and queues the result.
// ----------------------------------------------------------------------------
module esd_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] in_char
    input  wire esd_pkg::esd_qstat_t qstat,
    output logic                     push,
    output esd_pkg::esd_entry_t      push_entry
);
    import esd_pkg::*;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;
    localparam logic [1:0] PH_HEX2 = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic       nib_ok_reg, nib_ok_next;

    logic       accept;
    logic       emit;
    logic [4:0] hx;
    logic [7:0] c;

    assign s_axis_tready = !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && emit;
    assign c             = s_axis_tdata;
    assign hx            = hex_digit(c);

    always_comb
    begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        nib_ok_next = nib_ok_reg;
        emit       = 1'b0;
        push_entry = '{term_after: 1'b0, last: 1'b0, data: c};
        unique case (phase_reg)
            PH_TEXT:
            begin
                if (c == CH_NUL)
                begin
                    emit = 1'b1;
                    push_entry.last = 1'b1;
                end
                else if (c == CH_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_TEXT;
                emit       = 1'b1;
                case (c)
                    CH_NUL:       push_entry.last = 1'b1;
                    CH_LOWER_N:   push_entry.data = CH_LF;
                    CH_LOWER_T:   push_entry.data = CH_TAB;
                    CH_LOWER_R:   push_entry.data = CH_CR;
                    CH_ZERO:      push_entry.data = CH_NUL;
                    CH_LOWER_X:
                    begin
                        emit       = 1'b0;
                        phase_next = PH_HEX1;
                    end
                    default:      push_entry.data = c;
                endcase
            end
            PH_HEX1:
            begin
                if (c == CH_NUL)
                begin
                    // close the escape, then terminate
                    emit = 1'b1;
                    push_entry.data = CH_QUESTION;
                    push_entry.term_after = 1'b1;
                    phase_next = PH_TEXT;
                end
                else
                begin
                    nib_ok_next = hx[4];
                    nib_next    = hx[3:0];
                    phase_next  = PH_HEX2;
                end
            end
            PH_HEX2:
            begin
                emit = 1'b1;
                push_entry.term_after = (c == CH_NUL);
                if (!nib_ok_reg)
                    push_entry.data = CH_QUESTION;
                else if (c != CH_NUL && hx[4])
                    push_entry.data = {nib_reg, hx[3:0]};
                else
                    push_entry.data = {4'h0, nib_reg};
                phase_next = PH_TEXT;
            end
            default:
            begin
                phase_next = PH_TEXT;
            end
        endcase
        if (phase_next == PH_TEXT)
        begin
            nib_next    = 4'h0;
            nib_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TEXT;
            nib_reg    <= 4'h0;
            nib_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            nib_reg    <= nib_next;
            nib_ok_reg <= nib_ok_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/esd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_queue
// Short first-in first-out queue of results between front and back.
// ----------------------------------------------------------------------------
module esd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire esd_pkg::esd_entry_t push_entry,
    input  wire logic                pop,
    output esd_pkg::esd_entry_t      head,
    output esd_pkg::esd_qstat_t      qstat
);
    import esd_pkg::*;

    esd_entry_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/esd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_back
// Drains queued results into the output register, one beat per cycle if ready.
// ----------------------------------------------------------------------------
module esd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire esd_pkg::esd_entry_t head,
    input  wire esd_pkg::esd_qstat_t qstat,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,   // [7:0] out_byte
    output logic                     m_axis_tlast
);
    import esd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       term_reg, term_next;
    logic       load;

    assign load = !valid_reg || m_axis_tready;
    assign pop  = load && !term_reg && !qstat.empty;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        term_next  = term_reg;
        if (load)
        begin
            if (term_reg)
            begin
                // follow up with the terminator
                valid_next = 1'b1;
                data_next  = CH_NUL;
                last_next  = 1'b1;
                term_next  = 1'b0;
            end
            else if (!qstat.empty)
            begin
                valid_next = 1'b1;
                data_next  = head.data;
                last_next  = head.last;
                term_next  = head.term_after;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            term_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            term_reg  <= term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule
`default_nettype wire

>>> hdl/escape_sequence_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// Unescapes backslash sequences of a zero-terminated character stream.
//
//   channel   dir  tdata            tuser  tlast
//   s_axis    in   [7:0] in_char    -      -
//   m_axis    out  [7:0] out_byte   -      is_last
//
// Takes one character per cycle while s_axis_tready is high; a beat passes
// through the result queue and the output register. A zero that ends a hex
// escape yields two beats, which leave one per cycle unless m_axis stalls.
// A four-entry result queue lets the input side run while the output stalls;
// s_axis_tready drops only when that queue is full.
// Reset clears the escape state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] in_char
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
    output logic            m_axis_tlast
);
    import esd_pkg::*;

    esd_qstat_t qstat;
    esd_entry_t push_entry;
    esd_entry_t head;
    logic       push;
    logic       pop;

    esd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .qstat         (qstat),
        .push          (push),
        .push_entry    (push_entry)
    );

    esd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    esd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // a terminator beat always carries a zero byte
    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_NUL)
        else $error("terminator beat with non-zero data");

    // a raw zero always leaves something on its way out
    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata == CH_NUL
        |=> m_axis_tvalid || !qstat.empty)
        else $error("end of string lost");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue both full and empty");
`endif

endmodule
`default_nettype wire
